// ===== sv/gmse_pkg.sv =====
// ---------------------------------------------------------------------------
// gmse_pkg
// shared types and constants of the grey-mean-sobel edge stream
// ---------------------------------------------------------------------------
package gmse_pkg;

    localparam int W_W        = 11;    // width register and column counters
    localparam int H_W        = 13;    // height register
    localparam int Y_W        = 12;    // row counters
    localparam int MAX_HEIGHT = 4096;
    localparam int WIN_N      = 9;     // entries of a 3x3 window
    localparam int K_W        = 4;     // window index

    // floor(s/3) for s < 1024 and floor(s/9) for s < 4096 by reciprocal
    localparam logic [14:0] GREY_RECIP = 15'd21846;
    localparam logic [12:0] MEAN_RECIP = 13'd7282;

    // register indexes
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_GX     = 2'd2;
    localparam logic [1:0] REG_GY     = 2'd3;

    localparam logic [W_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [H_W-1:0] HEIGHT_RESET = 13'd480;

    typedef struct packed {
        logic       operation;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_in_item;

    typedef struct packed {
        logic [7:0] edge_magnitude;
        logic [7:0] gx_clamped;
        logic [7:0] gy_clamped;
        logic       end_of_frame;
    } t_out_item;

    // one command from the front to the back
    typedef struct packed {
        logic             grey_we;
        logic [7:0]       grey_val;
        logic [W_W-1:0]   grey_x;
        logic [1:0]       grey_y2;
        logic             mean_do;
        logic [W_W-1:0]   mean_x;
        logic [1:0]       mean_y2;
        logic [WIN_N-1:0] mean_mask;
        logic             out_do;
        logic [W_W-1:0]   out_x;
        logic [1:0]       out_y2;
        logic [WIN_N-1:0] out_mask;
        logic             eof;
    } t_cmd;

    typedef struct packed {
        logic pop;
        logic empty;
    } t_q_ctrl;

    typedef enum logic [2:0] {
        B_IDLE,
        B_READ,
        B_MEAN_WR,
        B_CLAMP,
        B_SQUARE,
        B_SUM,
        B_ROOT,
        B_EMIT
    } t_bstate;

    // column and row offset (0..2) of a window entry
    function automatic logic [1:0] win_dx(input logic [K_W-1:0] k);
        logic [1:0] d;
        case (k)
            4'd0, 4'd3, 4'd6: d = 2'd0;
            4'd1, 4'd4, 4'd7: d = 2'd1;
            default:          d = 2'd2;
        endcase
        return d;
    endfunction

    function automatic logic [1:0] win_dy(input logic [K_W-1:0] k);
        logic [1:0] d;
        case (k)
            4'd0, 4'd1, 4'd2: d = 2'd0;
            4'd3, 4'd4, 4'd5: d = 2'd1;
            default:          d = 2'd2;
        endcase
        return d;
    endfunction

endpackage

// ===== sv/gmse_front.sv =====
// ---------------------------------------------------------------------------
// gmse_front
// accepts pixels and flushes, tracks frame position, issues back commands
// ---------------------------------------------------------------------------
module gmse_front
    import gmse_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  t_in_item       i_data,
    input  logic           i_full,
    input  logic [W_W-1:0] i_width,
    input  logic [H_W-1:0] i_height,
    output logic           o_push,
    output t_cmd           o_cmd
);

    localparam int POS_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 2 * MAX_WIDTH + 4);

    logic             r_frame_done;
    logic [POS_W-1:0] r_pos;
    logic [W_W-1:0]   r_col;
    logic [1:0]       r_row2;
    logic [W_W-1:0]   r_fw;
    logic [H_W-1:0]   r_fh;
    logic [POS_W-1:0] r_total;
    logic [W_W-1:0]   r_mx, r_ox;
    logic [Y_W-1:0]   r_my, r_oy;

    logic             acc, op, fd_start, start, pix, mean_act, out_act, drop, eof;
    logic [POS_W-1:0] pos_e, lag, lag2;
    logic [W_W-1:0]   col_e, mx_e, ox_e, sat_w;
    logic [1:0]       row_e;
    logic [Y_W-1:0]   my_e, oy_e;
    logic [H_W-1:0]   sat_h;
    logic [9:0]       rgb_sum;
    logic [24:0]      grey_prod;

    function automatic logic [WIN_N-1:0] nb_mask(input logic [W_W-1:0] x,
                                                 input logic [Y_W-1:0] y,
                                                 input logic [W_W-1:0] fw,
                                                 input logic [H_W-1:0] fh);
        logic [2:0] cx, cy;
        logic [WIN_N-1:0] m;
        cx[0] = (x != '0);
        cx[1] = 1'b1;
        cx[2] = ((W_W+1)'(x) + 1'b1) < (W_W+1)'(fw);
        cy[0] = (y != '0);
        cy[1] = 1'b1;
        cy[2] = ((H_W+1)'(y) + 1'b1) < (H_W+1)'(fh);
        for (int k = 0; k < WIN_N; k++) begin
            m[k] = cx[k % 3] & cy[k / 3];
        end
        return m;
    endfunction

    always_comb begin
        acc      = i_valid && !i_full;
        op       = i_data.operation;
        fd_start = r_frame_done;
        pos_e    = fd_start ? '0 : r_pos;
        col_e    = fd_start ? '0 : r_col;
        row_e    = fd_start ? '0 : r_row2;
        start    = (pos_e == '0) && !op;
        mx_e     = start ? '0 : r_mx;
        my_e     = start ? '0 : r_my;
        ox_e     = start ? '0 : r_ox;
        oy_e     = start ? '0 : r_oy;

        sat_w = i_width;
        if (i_width == '0) sat_w = W_W'(1);
        else if (32'(i_width) > MAX_WIDTH) sat_w = W_W'(MAX_WIDTH);
        sat_h = i_height;
        if (i_height == '0) sat_h = H_W'(1);
        else if (32'(i_height) > MAX_HEIGHT) sat_h = H_W'(MAX_HEIGHT);

        // at frame start no window is due yet, so the old size is never used
        lag      = POS_W'(r_fw) + 1'b1;
        lag2     = lag + lag;
        pix      = start || (pos_e < r_total);
        mean_act = !start && (pos_e >= lag) && ((pos_e - lag) < r_total);
        out_act  = !start && (pos_e >= lag2) && ((pos_e - lag2) < r_total);
        eof      = (ox_e == r_fw - 1'b1) && (13'(oy_e) == r_fh - 1'b1);

        // flush after the frame, or flush while pixels are still due
        drop = (r_frame_done && op) || (pix && op);

        rgb_sum   = 10'(i_data.red) + 10'(i_data.green) + 10'(i_data.blue);
        grey_prod = 25'(rgb_sum) * 25'(GREY_RECIP);

        o_cmd.grey_we   = pix && !op;
        o_cmd.grey_val  = grey_prod[23:16];
        o_cmd.grey_x    = col_e;
        o_cmd.grey_y2   = row_e;
        o_cmd.mean_do   = mean_act;
        o_cmd.mean_x    = mx_e;
        o_cmd.mean_y2   = my_e[1:0];
        o_cmd.mean_mask = nb_mask(mx_e, my_e, r_fw, r_fh);
        o_cmd.out_do    = out_act;
        o_cmd.out_x     = ox_e;
        o_cmd.out_y2    = oy_e[1:0];
        o_cmd.out_mask  = nb_mask(ox_e, oy_e, r_fw, r_fh);
        o_cmd.eof       = eof;
        o_push          = acc && !drop;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_done <= 1'b0;
            r_pos        <= '0;
            r_col        <= '0;
            r_row2       <= '0;
            r_fw         <= WIDTH_RESET;
            r_fh         <= HEIGHT_RESET;
            r_total      <= POS_W'(WIDTH_RESET) * POS_W'(HEIGHT_RESET);
            r_mx         <= '0;
            r_my         <= '0;
            r_ox         <= '0;
            r_oy         <= '0;
        end else if (o_push) begin
            if (start) begin
                r_fw    <= sat_w;
                r_fh    <= sat_h;
                r_total <= POS_W'(sat_w) * POS_W'(sat_h);
            end
            r_frame_done <= out_act && eof;
            r_pos        <= pos_e + 1'b1;
            if (col_e + 1'b1 == (start ? sat_w : r_fw)) begin
                r_col  <= '0;
                r_row2 <= row_e + 1'b1;
            end else begin
                r_col  <= col_e + 1'b1;
                r_row2 <= row_e;
            end
            r_mx <= mx_e;
            r_my <= my_e;
            if (mean_act) begin
                if (mx_e + 1'b1 == r_fw) begin
                    r_mx <= '0;
                    r_my <= my_e + 1'b1;
                end else begin
                    r_mx <= mx_e + 1'b1;
                end
            end
            r_ox <= ox_e;
            r_oy <= oy_e;
            if (out_act) begin
                if (ox_e + 1'b1 == r_fw) begin
                    r_ox <= '0;
                    r_oy <= oy_e + 1'b1;
                end else begin
                    r_ox <= ox_e + 1'b1;
                end
            end
        end
    end

endmodule

// ===== sv/gmse_queue.sv =====
// ---------------------------------------------------------------------------
// gmse_queue
// short command queue between front and back
// ---------------------------------------------------------------------------
module gmse_queue
    import gmse_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_cmd,
    input  t_q_ctrl i_ctrl,
    output logic    o_full,
    output logic    o_empty,
    output t_cmd    o_cmd
);

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [PW:0]   r_cnt;
    logic          do_pop;

    assign o_full  = (r_cnt == (PW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_pop  = i_ctrl.pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push && !o_full) r_wr <= r_wr + 1'b1;
            if (do_pop) r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(i_push && !o_full) - (PW+1)'(do_pop);
        end
    end

endmodule

// ===== sv/gmse_back.sv =====
// ---------------------------------------------------------------------------
// gmse_back
// line memories, window sums, clamp, root and the output register
// ---------------------------------------------------------------------------
module gmse_back
    import gmse_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int COEFF_BITS = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_cmd                        i_cmd,
    input  logic                        i_empty,
    output t_q_ctrl                     o_ctrl,
    input  logic [WIN_N*COEFF_BITS-1:0] i_gx_kernel,
    input  logic [WIN_N*COEFF_BITS-1:0] i_gy_kernel,
    output logic                        o_valid,
    input  logic                        i_stall,
    output t_out_item                   o_data
);

    localparam int DEPTH = 4 * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int ACC_W = COEFF_BITS + 12;
    localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_WIDTH);

    logic [7:0] grey_mem [DEPTH];
    logic [7:0] mean_mem [DEPTH];

    t_bstate r_state, n_state;
    t_cmd    r_cmd;

    logic                    r_mode;   // 0 mean of grey, 1 gradients of mean
    logic [K_W-1:0]          r_k, r_pidx;
    logic                    r_pend;
    logic [11:0]             r_msum;
    logic signed [ACC_W-1:0] r_gx, r_gy;
    logic [7:0]              r_gxc, r_gyc, r_root;
    logic [15:0]             r_sqx, r_sqy;
    logic [16:0]             r_ssum;
    logic [2:0]              r_bit;
    logic [7:0]              r_grey_rd, r_mean_rd;
    logic                    r_ovalid;
    t_out_item               r_odata;

    logic                    pop, init_mean, init_out, mean_we, load_out, out_free;
    logic [AW-1:0]           raddr, mean_waddr, grey_waddr;
    logic [W_W-1:0]          rx;
    logic [1:0]              ry;
    logic [WIN_N-1:0]        rmask;
    logic [7:0]              rdata, dsel, trial;
    logic [24:0]             mean_prod;
    logic signed [COEFF_BITS-1:0] cx, cy;
    logic signed [COEFF_BITS+8:0] px, py;

    function automatic logic [AW-1:0] ring_addr(input logic [1:0] y2,
                                                input logic [W_W-1:0] x);
        return AW'(y2) * ROW_STRIDE + AW'(x);
    endfunction

    function automatic logic [7:0] clamp8(input logic signed [ACC_W-1:0] v);
        logic [7:0] c;
        if (v[ACC_W-1]) c = 8'd0;
        else if (v > ACC_W'(255)) c = 8'd255;
        else c = v[7:0];
        return c;
    endfunction

    assign out_free = !r_ovalid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= B_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        n_state   = r_state;
        pop       = 1'b0;
        init_mean = 1'b0;
        init_out  = 1'b0;
        mean_we   = 1'b0;
        load_out  = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    pop = 1'b1;
                    if (i_cmd.mean_do) begin
                        init_mean = 1'b1;
                        n_state   = B_READ;
                    end else if (i_cmd.out_do) begin
                        init_out = 1'b1;
                        n_state  = B_READ;
                    end
                end
            end
            B_READ: begin
                if (r_k == K_W'(WIN_N)) n_state = r_mode ? B_CLAMP : B_MEAN_WR;
            end
            B_MEAN_WR: begin
                mean_we = 1'b1;
                if (r_cmd.out_do) begin
                    init_out = 1'b1;
                    n_state  = B_READ;
                end else begin
                    n_state = B_IDLE;
                end
            end
            B_CLAMP:  n_state = B_SQUARE;
            B_SQUARE: n_state = B_SUM;
            B_SUM:    n_state = B_ROOT;
            B_ROOT: begin
                if (r_bit == '0) n_state = B_EMIT;
            end
            B_EMIT: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    assign o_ctrl.pop   = pop;
    assign o_ctrl.empty = i_empty;

    // window read address for entry r_k
    always_comb begin
        rx    = r_mode ? r_cmd.out_x : r_cmd.mean_x;
        ry    = r_mode ? r_cmd.out_y2 : r_cmd.mean_y2;
        rmask = r_mode ? r_cmd.out_mask : r_cmd.mean_mask;
        raddr = ring_addr(ry + win_dy(r_k) + 2'd3, rx + W_W'(win_dx(r_k)) - 1'b1);
        rdata = r_mode ? r_mean_rd : r_grey_rd;
        // neighbors outside the image count as zero
        dsel  = rmask[r_pidx] ? rdata : 8'd0;
        cx    = i_gx_kernel[r_pidx*COEFF_BITS +: COEFF_BITS];
        cy    = i_gy_kernel[r_pidx*COEFF_BITS +: COEFF_BITS];
        px    = cx * $signed({1'b0, dsel});
        py    = cy * $signed({1'b0, dsel});
        mean_prod  = 25'(r_msum) * 25'(MEAN_RECIP);
        mean_waddr = ring_addr(r_cmd.mean_y2, r_cmd.mean_x);
        grey_waddr = ring_addr(i_cmd.grey_y2, i_cmd.grey_x);
        trial      = r_root | (8'd1 << r_bit);
    end

    always_ff @(posedge i_clk) begin
        if (pop && i_cmd.grey_we) grey_mem[grey_waddr] <= i_cmd.grey_val;
        if (mean_we) mean_mem[mean_waddr] <= mean_prod[23:16];
        r_grey_rd <= grey_mem[raddr];
        r_mean_rd <= mean_mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_k    <= '0;
        end else begin
            if (init_mean || init_out) begin
                r_k    <= '0;
                r_pend <= 1'b0;
            end else if (r_state == B_READ) begin
                r_pend <= (r_k != K_W'(WIN_N));
                if (r_k != K_W'(WIN_N)) r_k <= r_k + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) r_cmd <= i_cmd;
        if (init_mean || init_out) begin
            r_mode <= init_out;
            r_msum <= '0;
            r_gx   <= '0;
            r_gy   <= '0;
        end else if (r_state == B_READ) begin
            r_pidx <= r_k;
            if (r_pend) begin
                r_msum <= r_msum + 12'(dsel);
                r_gx   <= r_gx + ACC_W'(px);
                r_gy   <= r_gy + ACC_W'(py);
            end
        end
        case (r_state)
            B_CLAMP: begin
                r_gxc <= clamp8(r_gx);
                r_gyc <= clamp8(r_gy);
            end
            B_SQUARE: begin
                r_sqx <= 16'(r_gxc) * 16'(r_gxc);
                r_sqy <= 16'(r_gyc) * 16'(r_gyc);
            end
            B_SUM: begin
                r_ssum <= 17'(r_sqx) + 17'(r_sqy);
                r_root <= '0;
                r_bit  <= 3'd7;
            end
            B_ROOT: begin
                if (16'(trial) * 16'(trial) <= r_ssum[15:0]) r_root <= trial;
                r_bit <= r_bit - 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (load_out) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_odata.edge_magnitude <= r_ssum[16] ? 8'd255 : r_root;
            r_odata.gx_clamped     <= r_gxc;
            r_odata.gy_clamped     <= r_gyc;
            r_odata.end_of_frame   <= r_cmd.eof;
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_odata;

endmodule

// ===== sv/grey_mean_sobel_edge_stream_top.sv =====
// ---------------------------------------------------------------------------
// grey_mean_sobel_edge_stream_top
// rgb pixel stream to grey, 3x3 mean, two programmable kernels, edge magnitude
// ---------------------------------------------------------------------------
// The front end takes one beat per clock, while the four-entry command queue
// is not full; the back end works through each pixel in turn (9 reads for the mean
// window, 9 for the gradient window, one write-back, clamp, square, sum, an 8-step
// root and the output load), paced by the single read port of each line memory,
// and takes no new command until it is done with the last. Each result lags its pixel by two
// rows plus two pixels; flush beats after the last pixel drain that lag, and
// end_of_frame marks the last result. Line memories need no clearing pass.
module grey_mean_sobel_edge_stream_top
    import gmse_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int COEFF_BITS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int KW = WIN_N * COEFF_BITS;

    logic [W_W-1:0] r_width;
    logic [H_W-1:0] r_height;
    logic [KW-1:0]  r_gx_kernel, r_gy_kernel;

    logic      q_push, q_full, q_empty, cfg_wr;
    t_cmd      f_cmd, q_cmd;
    t_q_ctrl   q_ctrl;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= WIDTH_RESET;
            r_height    <= HEIGHT_RESET;
            r_gx_kernel <= '0;
            r_gy_kernel <= '0;
        end else if (cfg_wr) begin
            case (paddr[4:3])
                REG_WIDTH:  r_width     <= pwdata[W_W-1:0];
                REG_HEIGHT: r_height    <= pwdata[H_W-1:0];
                REG_GX:     r_gx_kernel <= pwdata[KW-1:0];
                REG_GY:     r_gy_kernel <= pwdata[KW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[4:3])
            REG_WIDTH:  prdata = 64'(r_width);
            REG_HEIGHT: prdata = 64'(r_height);
            REG_GX:     prdata = 64'(r_gx_kernel);
            REG_GY:     prdata = 64'(r_gy_kernel);
            default:    prdata = '0;
        endcase
    end

    assign o_in_stall = q_full;

    gmse_front #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .i_data   (i_in_data),
        .i_full   (q_full),
        .i_width  (r_width),
        .i_height (r_height),
        .o_push   (q_push),
        .o_cmd    (f_cmd)
    );

    gmse_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (f_cmd),
        .i_ctrl  (q_ctrl),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_cmd   (q_cmd)
    );

    gmse_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .COEFF_BITS (COEFF_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (q_cmd),
        .i_empty     (q_empty),
        .o_ctrl      (q_ctrl),
        .i_gx_kernel (r_gx_kernel),
        .i_gy_kernel (r_gy_kernel),
        .o_valid     (o_out_valid),
        .i_stall     (i_out_stall),
        .o_data      (o_out_data)
    );

    // magnitude lies between the larger gradient and the sum of both
    a_mag_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.edge_magnitude >= o_out_data.gx_clamped)
                     && (o_out_data.edge_magnitude >= o_out_data.gy_clamped))
        else $error("edge magnitude below a gradient");

    a_mag_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (9'(o_out_data.edge_magnitude)
                         <= 9'(o_out_data.gx_clamped) + 9'(o_out_data.gy_clamped)))
        else $error("edge magnitude above gradient sum");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("beat pending after reset");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// pixel stream test of the grey-mean-sobel edge block: random frames of many
// sizes and kernels are predicted in the bench and checked beat by beat
// ---------------------------------------------------------------------------
module tb_top;
    import gmse_pkg::*;

    localparam int MAXW      = 1024;
    localparam int LIMIT     = 4000000;
    localparam int SETTLE    = 400;
    localparam logic OP_PIX  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_item   o_out_data;
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    grey_mean_sobel_edge_stream_top uut (.*);

    // edge predictor state
    logic [10:0] cfg_w;
    logic [12:0] cfg_h;
    logic [35:0] kern_x, kern_y;
    logic [7:0]  grey_mem [4*MAXW];
    logic [7:0]  mean_mem [4*MAXW];
    int          col_in, row_in, lat_w, lat_h;
    bit          frame_over;

    t_in_item    pixel_q [$];
    t_out_item   edge_q [$];
    bit          beat_taken;
    bit          calm;
    int          hold_left;
    int          cyc, errs;

    // stimulus generator bookkeeping
    int          gen_pix, gen_drain, gen_w;
    int          item_cnt;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int sat_w(input logic [10:0] w);
        return (w == 0) ? 1 : ((w > MAXW) ? MAXW : int'(w));
    endfunction

    function automatic int sat_h(input logic [12:0] h);
        return (h == 0) ? 1 : ((h > 4096) ? 4096 : int'(h));
    endfunction

    function automatic int ring(input int x, input int y);
        return (y % 4) * MAXW + (x % MAXW);
    endfunction

    function automatic int clip8(input int v);
        return (v < 0) ? 0 : ((v > 255) ? 255 : v);
    endfunction

    // mode 0: grey sum, 1: gx over mean, 2: gy over mean
    function automatic int window_sum(input int x, input int y, input int mode);
        int acc, xx, yy;
        logic signed [3:0] c;
        acc = 0;
        for (int dy = 0; dy < 3; dy++) begin
            for (int dx = 0; dx < 3; dx++) begin
                xx = x + dx - 1;
                yy = y + dy - 1;
                if (xx < 0 || yy < 0 || xx >= lat_w || yy >= lat_h) continue;
                if (mode == 0) begin
                    acc += grey_mem[ring(xx, yy)];
                end else begin
                    c = (mode == 1) ? kern_x[(dy*3+dx)*4 +: 4] : kern_y[(dy*3+dx)*4 +: 4];
                    acc += int'(c) * int'(mean_mem[ring(xx, yy)]);
                end
            end
        end
        return acc;
    endfunction

    function automatic int root_floor(input int s);
        int r;
        r = 0;
        while ((r + 1) * (r + 1) <= s) r++;
        return r;
    endfunction

    task automatic predict_edge(input t_in_item it);
        int pos, total, lag, q, o, gx, gy, mag;
        t_out_item res;
        if (frame_over) begin
            if (it.operation == OP_FLUSH) return;
            frame_over = 0;
            col_in = 0;
            row_in = 0;
        end
        pos = row_in * lat_w + col_in;
        if (pos == 0 && it.operation == OP_PIX) begin
            lat_w = sat_w(cfg_w);
            lat_h = sat_h(cfg_h);
        end
        total = lat_w * lat_h;
        lag = lat_w + 1;
        if (pos < total) begin
            if (it.operation == OP_FLUSH) return;
            grey_mem[ring(col_in, row_in)] =
                8'((int'(it.red) + int'(it.green) + int'(it.blue)) / 3);
        end
        if (pos >= lag && pos - lag < total) begin
            q = pos - lag;
            mean_mem[ring(q % lat_w, q / lat_w)] =
                8'(clip8(window_sum(q % lat_w, q / lat_w, 0) / 9));
        end
        if (pos >= 2 * lag && pos - 2 * lag < total) begin
            o = pos - 2 * lag;
            gx = clip8(window_sum(o % lat_w, o / lat_w, 1));
            gy = clip8(window_sum(o % lat_w, o / lat_w, 2));
            mag = root_floor(gx * gx + gy * gy);
            if (mag > 255) mag = 255;
            res.edge_magnitude = 8'(mag);
            res.gx_clamped = 8'(gx);
            res.gy_clamped = 8'(gy);
            res.end_of_frame = (o == total - 1);
            if (o == total - 1) frame_over = 1;
            edge_q.push_back(res);
        end
        col_in++;
        if (col_in >= lat_w) begin
            col_in = 0;
            row_in++;
        end
    endtask

    // ---------------- driver and receiver ----------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !beat_taken) begin
            // stalled beat holds
        end else if (pixel_q.size() > 0 && (calm || $urandom_range(99) >= 22)) begin
            i_in_valid <= 1'b1;
            i_in_data <= pixel_q.pop_front();
        end else begin
            i_in_valid <= 1'b0;
        end
        beat_taken = 0;
    end

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !calm && ($urandom_range(99) < 22);
        end
    end

    // ---------------- monitor ----------------
    always @(posedge i_clk) begin
        t_out_item want;
        cyc++;
        if (cyc > LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            beat_taken = 1;
            predict_edge(i_in_data);
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (edge_q.size() == 0) begin
                errs++;
                if (errs <= 10) $display("unexpected beat %p", o_out_data);
            end else begin
                want = edge_q.pop_front();
                if (want !== o_out_data) begin
                    errs++;
                    if (errs <= 10)
                        $display("mismatch at cycle %0d: expected %p actual %p",
                                 cyc, want, o_out_data);
                end
            end
        end
    end

    // ---------------- stimulus ----------------
    task automatic reg_write(input logic [1:0] idx, input logic [63:0] val);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_WIDTH:  cfg_w = val[10:0];
            REG_HEIGHT: cfg_h = val[12:0];
            REG_GX:     kern_x = val[35:0];
            default:    kern_y = val[35:0];
        endcase
    endtask

    task automatic drain_wait();
        while (pixel_q.size() > 0 || i_in_valid || edge_q.size() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [7:0] chan();
        int r;
        r = $urandom_range(9);
        return (r == 0) ? 8'd0 : ((r == 1) ? 8'd255 : 8'($urandom));
    endfunction

    function automatic t_in_item mk(input logic op);
        t_in_item it;
        it.operation = op;
        it.red = chan();
        it.green = chan();
        it.blue = chan();
        return it;
    endfunction

    // push n counted beats that follow the frame structure, with some noise
    task automatic feed_frames(input int n);
        for (int k = 0; k < n; k++) begin
            if (gen_pix == 0 && gen_drain == 0) begin
                // flushes after frame end are ignored
                if ($urandom_range(3) == 0) pixel_q.push_back(mk(OP_FLUSH));
                gen_w = sat_w(cfg_w);
                gen_pix = gen_w * sat_h(cfg_h);
                gen_drain = 2 * gen_w + 2;
            end
            if (gen_pix > 0) begin
                if ($urandom_range(99) < 6) pixel_q.push_back(mk(OP_FLUSH));
                pixel_q.push_back(mk(OP_PIX));
                gen_pix--;
            end else begin
                pixel_q.push_back(mk(($urandom_range(99) < 15) ? OP_PIX : OP_FLUSH));
                gen_drain--;
            end
            item_cnt++;
        end
    endtask

    task automatic finish_frame();
        feed_frames(gen_pix + gen_drain);
    endtask

    initial begin
        int ph;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cfg_w = WIDTH_RESET;
        cfg_h = HEIGHT_RESET;
        kern_x = '0;
        kern_y = '0;
        col_in = 0;
        row_in = 0;
        frame_over = 0;
        lat_w = sat_w(cfg_w);
        lat_h = sat_h(cfg_h);
        calm = 0;
        hold_left = 0;
        cyc = 0;
        errs = 0;
        gen_pix = 0;
        gen_drain = 0;
        item_cnt = 0;
        beat_taken = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed 3x3 frame, coefficient extremes -8 and 7
        reg_write(REG_WIDTH, 64'd3);
        reg_write(REG_HEIGHT, 64'd3);
        reg_write(REG_GX, 64'h0_7780_08F8_8);
        reg_write(REG_GY, 64'h8_8877_7F08_8);
        pixel_q.push_back('{OP_PIX, 8'd0, 8'd0, 8'd0});
        pixel_q.push_back('{OP_FLUSH, 8'd9, 8'd9, 8'd9});   // flush mid frame
        pixel_q.push_back('{OP_PIX, 8'd255, 8'd255, 8'd255});
        pixel_q.push_back('{OP_PIX, 8'd255, 8'd0, 8'd0});
        pixel_q.push_back('{OP_PIX, 8'd0, 8'd255, 8'd0});
        pixel_q.push_back('{OP_PIX, 8'd0, 8'd0, 8'd255});
        pixel_q.push_back('{OP_PIX, 8'd255, 8'd255, 8'd255});
        pixel_q.push_back('{OP_PIX, 8'd255, 8'd255, 8'd254});
        pixel_q.push_back('{OP_PIX, 8'd1, 8'd1, 8'd1});
        pixel_q.push_back('{OP_PIX, 8'd255, 8'd255, 8'd255});
        for (int k = 0; k < 8; k++)
            pixel_q.push_back('{(k == 3) ? OP_PIX : OP_FLUSH, 8'd77, 8'd88, 8'd99});
        pixel_q.push_back('{OP_FLUSH, 8'd0, 8'd0, 8'd0});   // ignored after end
        drain_wait();

        // wide single row, height saturated up from zero
        reg_write(REG_WIDTH, 64'd200);
        reg_write(REG_HEIGHT, 64'd0);
        reg_write(REG_GX, {28'd0, 36'hFFFF_FFFFF});
        reg_write(REG_GY, {28'd0, 36'h7777_77777});
        feed_frames(1);
        finish_frame();
        drain_wait();
        reg_write(REG_HEIGHT, 64'd8191);

        ph = 0;
        while (item_cnt < 1430) begin
            reg_write(REG_WIDTH, ($urandom_range(7) == 0) ? 64'($urandom_range(1))
                                                          : 64'($urandom_range(2, 9)));
            reg_write(REG_HEIGHT, ($urandom_range(7) == 0) ? 64'd1
                                                           : 64'($urandom_range(2, 6)));
            reg_write(REG_GX, {28'd0, 4'($urandom), 32'($urandom)});
            reg_write(REG_GY, {28'd0, 4'($urandom), 32'($urandom)});
            calm = (ph >= 6 && ph < 10);
            if (ph == 3) hold_left = 600;
            // sometimes stop mid frame so the next size waits for the frame start
            if ($urandom_range(3) == 0) feed_frames($urandom_range(5, 60));
            else finish_frame();
            feed_frames($urandom_range(0, 40));
            ph++;
            drain_wait();
        end
        calm = 0;
        finish_frame();
        drain_wait();

        if (errs == 0 && edge_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
